>>> rtl/rcam_pkg.sv
// Shared types, constants and the divider step for the rounded-corner alpha mask.
package rcam_pkg;

    localparam int IMG_BITS  = 12;
    localparam int RAD_BITS  = 8;
    localparam int CH_BITS   = 8;
    localparam int CFG_IDX_BITS = 3;

    // Depth of the queue between classifier and blend pipeline
    localparam int MID_DEPTH = 4;
    // Result queue depth; must cover the blend pipeline so that credits never starve it
    localparam int OUT_DEPTH = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_LT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_RT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_LB = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_RB = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT    = 3'd5;

    typedef struct packed {
        logic [CH_BITS-1:0] blue;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [RAD_BITS-1:0] rad_lt;
        logic [RAD_BITS-1:0] rad_rt;
        logic [RAD_BITS-1:0] rad_lb;
        logic [RAD_BITS-1:0] rad_rb;
        logic [IMG_BITS-1:0] width;
        logic [IMG_BITS-1:0] height;
    } cfg_t;

    // Classified pixel waiting for the blend pipeline
    typedef struct packed {
        pixel_t             pix;
        logic [CH_BITS-1:0] mask;
        logic               pass1;
        logic               pass2;
    } job_t;

    // One blend pass: act requests a pass on entry and reports a change on exit
    typedef struct packed {
        pixel_t             pix;
        logic [CH_BITS-1:0] mask;
        logic               act;
        logic               tag;
    } pass_t;

    typedef struct packed {
        pixel_t pix;
        logic   modified;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // One restoring division step: returns {remainder, shifted quotient}
    function automatic logic [2*CH_BITS-1:0] div_step(
        input logic [CH_BITS-1:0] rem,
        input logic [CH_BITS-1:0] quo,
        input logic [CH_BITS-1:0] divisor
    );
        logic [CH_BITS:0] trial;
        logic [CH_BITS:0] dvs;
        trial = {rem, quo[CH_BITS-1]};
        dvs   = {1'b0, divisor};
        if (trial >= dvs)
        begin
            return {CH_BITS'(trial - dvs), quo[CH_BITS-2:0], 1'b1};
        end
        return {trial[CH_BITS-1:0], quo[CH_BITS-2:0], 1'b0};
    endfunction

endpackage

>>> rtl/rcam_fifo.sv
// Small register queue with full/empty status, read data shown from the head entry.
module rcam_fifo import rcam_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output fifo_stat_t       stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem[rd_ptr_reg];

    // pointer and fill-level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(do_wr) - CW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/rcam_front.sv
// Front end: accepts a beat, decides which corner passes apply and holds the job for the queue.
module rcam_front import rcam_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  push,
    output logic                  full,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    input  logic [CH_BITS-1:0]    in_blue,
    input  logic [CH_BITS-1:0]    in_green,
    input  logic [CH_BITS-1:0]    in_red,
    input  logic [CH_BITS-1:0]    in_alpha,
    input  logic [CH_BITS-1:0]    mask_alpha,
    input  logic                  mid_full,
    output logic                  job_valid,
    output job_t                  job
);

    // wide enough for coordinate sums plus a radius without wrapping
    localparam int UW = ((COORD_BITS > IMG_BITS) ? COORD_BITS : IMG_BITS) + 2;
    localparam logic [UW-1:0] ONE = UW'(1);

    logic          valid_reg, valid_next;
    job_t          job_reg, job_next;
    logic          accept;
    logic [UW-1:0] x_w, y_w, w_w, h_w;
    logic [UW-1:0] lt_w, rt_w, lb_w, rb_w;
    logic [UW-1:0] sum_top, sum_bot, sum_left, sum_right;
    logic [UW-1:0] min_w, min_h;
    logic          fits;
    logic          hit_lt, hit_lb, hit_rt, hit_rb;

    assign full      = valid_reg && mid_full;
    assign accept    = push && !full;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    // corner classification
    always_comb
    begin
        x_w  = UW'(pixel_x);
        y_w  = UW'(pixel_y);
        w_w  = UW'(cfg.width);
        h_w  = UW'(cfg.height);
        lt_w = UW'(cfg.rad_lt);
        rt_w = UW'(cfg.rad_rt);
        lb_w = UW'(cfg.rad_lb);
        rb_w = UW'(cfg.rad_rb);

        sum_top   = lt_w + rt_w;
        sum_bot   = lb_w + rb_w;
        sum_left  = lt_w + lb_w;
        sum_right = rt_w + rb_w;
        min_w     = (sum_top > sum_bot) ? sum_top : sum_bot;
        min_h     = (sum_left > sum_right) ? sum_left : sum_right;

        fits = (w_w >= min_w) && (h_w >= min_h) && (x_w < w_w) && (y_w < h_w);

        hit_lt = (lt_w != '0) && (x_w + y_w < lt_w);
        hit_lb = (lb_w != '0) && (y_w + lb_w >= h_w) && (x_w + h_w <= y_w + lb_w);
        hit_rt = (rt_w != '0) && (y_w < rt_w) && (x_w + rt_w >= w_w + y_w);
        hit_rb = (rb_w != '0) && (y_w + rb_w >= h_w) && (x_w + rb_w >= w_w)
                 && (x_w + y_w + rb_w + ONE >= w_w + h_w);

        job_next.pix.blue  = in_blue;
        job_next.pix.green = in_green;
        job_next.pix.red   = in_red;
        job_next.pix.alpha = in_alpha;
        job_next.mask      = mask_alpha;
        job_next.pass1     = fits && (hit_lt || hit_lb || hit_rt || hit_rb);
        // only opposite corners on a square image can overlap
        job_next.pass2     = fits && ((hit_lt && hit_rb) || (hit_rt && hit_lb));
    end

    // holding stage
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (!mid_full)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

endmodule

>>> rtl/rcam_blend.sv
// One corner blend pass: alpha scaling, colour products and a pipelined restoring divider.
module rcam_blend import rcam_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  pass_t in_data,
    output logic  out_valid,
    output pass_t out_data
);

    localparam int DIV_STAGES      = 4;
    localparam int STEPS_PER_STAGE = CH_BITS / DIV_STAGES;

    typedef struct packed {
        pass_t                          d;
        logic [CH_BITS-1:0]             n;
        logic [2:0][CH_BITS-1:0]        rem;
        logic [2:0][CH_BITS-1:0]        quo;
    } stage_t;

    logic                    s1_valid_reg;
    pass_t                   s1_d_reg;
    logic [CH_BITS-1:0]      s1_n_reg, s1_n_next;
    logic [2*CH_BITS-1:0]    prod_an;

    logic                    s2_valid_reg;
    stage_t                  s2_reg, s2_next;
    logic [2:0][CH_BITS-1:0] col;
    logic [2:0][2*CH_BITS-1:0] prod_cn;

    logic [DIV_STAGES-1:0]   dv_valid_reg;
    stage_t                  dv_reg  [DIV_STAGES];
    stage_t                  dv_next [DIV_STAGES];

    stage_t                  last;
    logic                    apply;

    // new alpha
    assign prod_an   = in_data.pix.alpha * in_data.mask;
    assign s1_n_next = prod_an[2*CH_BITS-1:CH_BITS];

    // colour times new alpha, split into divider start state
    always_comb
    begin
        col[0] = s1_d_reg.pix.blue;
        col[1] = s1_d_reg.pix.green;
        col[2] = s1_d_reg.pix.red;
        s2_next.d = s1_d_reg;
        s2_next.n = s1_n_reg;
        for (int ch = 0; ch < 3; ch++)
        begin
            prod_cn[ch]     = col[ch] * s1_n_reg;
            s2_next.rem[ch] = prod_cn[ch][2*CH_BITS-1:CH_BITS];
            s2_next.quo[ch] = prod_cn[ch][CH_BITS-1:0];
        end
    end

    // divider stages, two quotient bits each
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        stage_t src;
        if (g == 0)
        begin : g_first
            assign src = s2_reg;
        end
        else
        begin : g_rest
            assign src = dv_reg[g-1];
        end

        always_comb
        begin
            logic [2*CH_BITS-1:0] rq;
            dv_next[g] = src;
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int st = 0; st < STEPS_PER_STAGE; st++)
                begin
                    rq = div_step(dv_next[g].rem[ch], dv_next[g].quo[ch], src.d.pix.alpha);
                    dv_next[g].rem[ch] = rq[2*CH_BITS-1:CH_BITS];
                    dv_next[g].quo[ch] = rq[CH_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            dv_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            dv_valid_reg <= {dv_valid_reg[DIV_STAGES-2:0], s2_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_d_reg <= in_data;
        s1_n_reg <= s1_n_next;
        s2_reg   <= s2_next;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            dv_reg[k] <= dv_next[k];
        end
    end

    // pass result; zero alpha leaves the pixel alone
    assign last  = dv_reg[DIV_STAGES-1];
    assign apply = last.d.act && (last.d.pix.alpha != '0);

    always_comb
    begin
        out_data           = last.d;
        out_data.act       = apply;
        if (apply)
        begin
            out_data.pix.blue  = last.quo[0];
            out_data.pix.green = last.quo[1];
            out_data.pix.red   = last.quo[2];
            out_data.pix.alpha = last.n;
        end
    end

    assign out_valid = dv_valid_reg[DIV_STAGES-1];

endmodule

>>> rtl/rounded_corner_alpha_mask.sv
// Rounded-corner alpha mask: classifier, job queue, two blend passes and result queue.
// Throughput: one pixel per cycle while credits are free; the 12-stage blend pipeline (two passes, each with a
// four-stage divider) is fed under credits from the 16-entry result queue.
// Reset: valid bits, queue pointers and the credit count clear; radii reset to 0 and
// image size to 1x1. Queue contents are not cleared.
module rounded_corner_alpha_mask import rcam_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [IMG_BITS-1:0]     cfg_data,
    // input beats
    input  logic                    push,
    output logic                    full,
    input  logic [COORD_BITS-1:0]   pixel_x,
    input  logic [COORD_BITS-1:0]   pixel_y,
    input  logic [CH_BITS-1:0]      in_blue,
    input  logic [CH_BITS-1:0]      in_green,
    input  logic [CH_BITS-1:0]      in_red,
    input  logic [CH_BITS-1:0]      in_alpha,
    input  logic [CH_BITS-1:0]      mask_alpha,
    // result beats
    output logic                    empty,
    input  logic                    pop,
    output logic [CH_BITS-1:0]      out_blue,
    output logic [CH_BITS-1:0]      out_green,
    output logic [CH_BITS-1:0]      out_red,
    output logic [CH_BITS-1:0]      out_alpha,
    output logic                    was_modified
);

    localparam int UCW = $clog2(OUT_DEPTH + 1);

    cfg_t           cfg_reg, cfg_next;
    logic           job_valid;
    job_t           job, mid_job;
    fifo_stat_t     mid_stat, out_stat;
    logic           mid_wr;
    logic           issue;
    logic [UCW-1:0] used_reg, used_next;
    logic           out_rd;
    pass_t          p1_in, p1_out, p2_in, p2_out;
    logic           p1_valid, p2_valid;
    result_t        res_in, res_out;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RADIUS_LT: cfg_next.rad_lt = cfg_data[RAD_BITS-1:0];
                CFG_RADIUS_RT: cfg_next.rad_rt = cfg_data[RAD_BITS-1:0];
                CFG_RADIUS_LB: cfg_next.rad_lb = cfg_data[RAD_BITS-1:0];
                CFG_RADIUS_RB: cfg_next.rad_rb = cfg_data[RAD_BITS-1:0];
                CFG_WIDTH:     cfg_next.width  = cfg_data;
                CFG_HEIGHT:    cfg_next.height = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rad_lt <= '0;
            cfg_reg.rad_rt <= '0;
            cfg_reg.rad_lb <= '0;
            cfg_reg.rad_rb <= '0;
            cfg_reg.width  <= IMG_BITS'(1);
            cfg_reg.height <= IMG_BITS'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end
    rcam_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .full       (full),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .in_blue    (in_blue),
        .in_green   (in_green),
        .in_red     (in_red),
        .in_alpha   (in_alpha),
        .mask_alpha (mask_alpha),
        .mid_full   (mid_stat.full),
        .job_valid  (job_valid),
        .job        (job)
    );

    assign mid_wr = job_valid && !mid_stat.full;

    // job queue between front and back
    rcam_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_wr),
        .wr_data (job),
        .rd_en   (issue),
        .rd_data (mid_job),
        .stat    (mid_stat)
    );

    // credits: every job in the blend pipeline has a result-queue slot reserved
    assign issue     = !mid_stat.empty && (used_reg < UCW'(OUT_DEPTH));
    assign out_rd    = pop && !out_stat.empty;
    assign used_next = used_reg + UCW'(issue) - UCW'(out_rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    // first corner pass
    always_comb
    begin
        p1_in.pix  = mid_job.pix;
        p1_in.mask = mid_job.mask;
        p1_in.act  = mid_job.pass1;
        p1_in.tag  = mid_job.pass2;
    end

    rcam_blend u_pass1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (issue),
        .in_data   (p1_in),
        .out_valid (p1_valid),
        .out_data  (p1_out)
    );

    // second pass for overlapping diagonals; tag now carries the modified flag
    always_comb
    begin
        p2_in.pix  = p1_out.pix;
        p2_in.mask = p1_out.mask;
        p2_in.act  = p1_out.tag;
        p2_in.tag  = p1_out.act;
    end

    rcam_blend u_pass2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p1_valid),
        .in_data   (p2_in),
        .out_valid (p2_valid),
        .out_data  (p2_out)
    );

    assign res_in.pix      = p2_out.pix;
    assign res_in.modified = p2_out.tag;

    // result queue
    rcam_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (p2_valid),
        .wr_data (res_in),
        .rd_en   (out_rd),
        .rd_data (res_out),
        .stat    (out_stat)
    );

    assign empty        = out_stat.empty;
    assign out_blue     = res_out.pix.blue;
    assign out_green    = res_out.pix.green;
    assign out_red      = res_out.pix.red;
    assign out_alpha    = res_out.pix.alpha;
    assign was_modified = res_out.modified;

`ifndef SYNTHESIS
    // credit count never exceeds the result queue
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UCW'(OUT_DEPTH))
        else $error("credit count above result queue depth");

    // a finished beat always finds room in the result queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid |-> !out_stat.full)
        else $error("blend result dropped at full result queue");

    // a waiting result always holds a credit
    a_result_credit: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stat.empty |-> (used_reg != '0))
        else $error("result waiting without a credit");
`endif

endmodule
